FILE: hw/rtl/cft_pkg.sv
// Package for the cumulative frequency table: command and status codes,
// sequencer states and field widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cft_pkg;

  localparam int CMD_W    = 2;
  localparam int SYM_W    = 8;
  localparam int WORD_W   = 32;
  localparam int STAT_W   = 2;
  localparam int CFG_W    = 9;

  localparam logic [WORD_W-1:0] WORD_MAX = '1;

  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INC   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SET   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;

  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MODIFY,
    S_SUM,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cft_if.sv
// Valid/ready channel interfaces for command items and result items.
// Depends on cft_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cft_in_if
  import cft_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [SYM_W-1:0]  symbol;
  logic [WORD_W-1:0] new_count;

  modport source (output valid, output command, output symbol, output new_count,
                  input ready);
  modport sink   (input valid, input command, input symbol, input new_count,
                  output ready);
endinterface

interface cft_out_if
  import cft_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [WORD_W-1:0] cum_low;
  logic [WORD_W-1:0] cum_high;
  logic [WORD_W-1:0] count;
  logic [WORD_W-1:0] grand_total;

  modport source (output valid, output status, output cum_low, output cum_high,
                  output count, output grand_total, input ready);
  modport sink   (input valid, input status, input cum_low, input cum_high,
                  input count, input grand_total, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/cumulative_frequency_table.sv
// Cumulative frequency table for an arithmetic coder: count memory, running
// total and a sequencer that sums counts through one adder.
// Depends on cft_pkg and the channel interfaces in cft_if.
//
// Usage: each item on in_if carries a command (query, increment, set), a
// symbol and a new count. One result item per command leaves on out_if with
// the status, cumulative low and high bound, count and total after the
// command. cfg_we/cfg_wdata write the alphabet size; the user is to write it
// only while the block is idle, which the block itself does not enforce.
// An out-of-range symbol goes from acceptance straight to the done state;
// otherwise the count is read and modified, then the prefix sum reads the
// count memory one entry per cycle through its single read port into one
// 32-bit accumulator. in_if.ready is high only while the sequencer is idle,
// so one item is in work at a time. A finished result waits in the output
// register; the next item is accepted meanwhile, and the sequencer holds its
// result until out_if is free. Reset: rst_n clears the total, the alphabet
// size returns to 256, and a clearing pass writes zero to every entry of the
// count memory in turn; no item is accepted during the pass.
`timescale 1ns / 1ps
`default_nettype none

module cumulative_frequency_table
  import cft_pkg::*;
#(
  parameter int MAX_SYMBOLS = 256
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  cft_in_if.sink                in_if,
  cft_out_if.source             out_if
);

  localparam int AW    = (MAX_SYMBOLS > 2) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int CW_MS = $clog2(MAX_SYMBOLS + 1);
  localparam int CW    = (CW_MS > CFG_W) ? CW_MS : CFG_W;
  localparam logic [CW-1:0] MAX_SYM_C = CW'(MAX_SYMBOLS);
  localparam logic [AW-1:0] LAST_IDX  = AW'(MAX_SYMBOLS - 1);

  logic [WORD_W-1:0] mem [MAX_SYMBOLS];
  logic [WORD_W-1:0] rdata_r;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;

  state_t            state_r, state_nxt;
  logic [CFG_W-1:0]  size_r;
  logic [WORD_W-1:0] total_r, total_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [AW-1:0]     sym_r, sym_nxt;
  logic [WORD_W-1:0] val_r, val_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic              pend_r, pend_nxt;
  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic [WORD_W-1:0] cnt_r, cnt_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r;
  logic [WORD_W-1:0] out_low_r, out_high_r, out_count_r, out_total_r;
  logic              out_load;

  logic [CW-1:0]     sym_ext;
  logic [CW-1:0]     size_ext;
  logic [CW-1:0]     eff_size;
  logic              sym_bad;
  logic [WORD_W-1:0] rest;
  logic [WORD_W:0]   set_sum;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  assign sym_ext  = CW'(in_if.symbol);
  assign size_ext = CW'(size_r);
  assign eff_size = (size_ext > MAX_SYM_C) ? MAX_SYM_C : size_ext;
  assign sym_bad  = (sym_ext >= eff_size);
  assign rest     = total_r - rdata_r;
  assign set_sum  = {1'b0, rest} + {1'b0, val_r};

  assign in_if.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    cmd_nxt       = cmd_r;
    sym_nxt       = sym_r;
    val_nxt       = val_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    stat_nxt      = stat_r;
    mem_we        = 1'b0;
    mem_waddr     = sym_r;
    mem_wdata     = '0;
    mem_raddr     = idx_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_if.ready;

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        idx_nxt   = idx_r + 1'b1;
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        mem_raddr = sym_ext[AW-1:0];
        if (in_if.valid) begin
          cmd_nxt = in_if.command;
          sym_nxt = sym_ext[AW-1:0];
          val_nxt = in_if.new_count;
          idx_nxt = '0;
          pend_nxt = 1'b0;
          acc_nxt = '0;
          if (sym_bad) begin
            cnt_nxt   = '0;
            stat_nxt  = STAT_RANGE;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_MODIFY;
          end
        end
      end
      S_MODIFY: begin
        stat_nxt  = STAT_OK;
        cnt_nxt   = rdata_r;
        state_nxt = S_SUM;
        case (cmd_r)
          CMD_INC: begin
            if (rdata_r == WORD_MAX || total_r == WORD_MAX) begin
              stat_nxt = STAT_OVERFLOW;
            end else begin
              cnt_nxt   = rdata_r + 1'b1;
              total_nxt = total_r + 1'b1;
              mem_we    = 1'b1;
              mem_wdata = rdata_r + 1'b1;
            end
          end
          CMD_SET: begin
            if (set_sum[WORD_W]) begin
              stat_nxt = STAT_OVERFLOW;
            end else begin
              cnt_nxt   = val_r;
              total_nxt = set_sum[WORD_W-1:0];
              mem_we    = 1'b1;
              mem_wdata = val_r;
            end
          end
          default: begin
          end
        endcase
      end
      S_SUM: begin
        if (pend_r) begin
          acc_nxt = acc_r + rdata_r;
        end
        if (idx_r != sym_r) begin
          idx_nxt  = idx_r + 1'b1;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      size_r      <= CFG_RESET;
      total_r     <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        size_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    sym_r  <= sym_nxt;
    val_r  <= val_nxt;
    acc_r  <= acc_nxt;
    cnt_r  <= cnt_nxt;
    stat_r <= stat_nxt;
    if (out_load) begin
      out_status_r <= stat_r;
      out_low_r    <= acc_r;
      out_high_r   <= acc_r + cnt_r;
      out_count_r  <= cnt_r;
      out_total_r  <= total_r;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.status      = out_status_r;
  assign out_if.cum_low     = out_low_r;
  assign out_if.cum_high    = out_high_r;
  assign out_if.count       = out_count_r;
  assign out_if.grand_total = out_total_r;

  a_acc_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUM) |-> (acc_r <= total_r))
    else $error("prefix sum exceeds total");

  a_result_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != STAT_RANGE) |->
      (out_low_r <= out_high_r && out_high_r <= out_total_r))
    else $error("result bounds out of order");

  a_clear_total: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (total_r == '0))
    else $error("total nonzero during clearing pass");

  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLEAR || state_r == S_MODIFY))
    else $error("count memory written outside clear or modify");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_if.ready))
    else $error("result register overwritten while held");

endmodule

`default_nettype wire

FILE: tb/sv/cumulative_frequency_table_tb.sv
// Self-checking testbench for cumulative_frequency_table: drives command items,
// predicts every result from its own frequency table copy and checks each field.
// Depends on cft_pkg, the channel interfaces in cft_if and the table RTL.
`timescale 1ns / 1ps

module cumulative_frequency_table_tb;
  import cft_pkg::*;

  localparam int MAX_SYM      = 256;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 300;
  localparam int STALL_CYCLES = 600;
  localparam int IDLE_PCT     = 35;

  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [WORD_W-1:0] cum_low;
    logic [WORD_W-1:0] cum_high;
    logic [WORD_W-1:0] count;
    logic [WORD_W-1:0] grand_total;
  } freq_result_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  cft_in_if  in_ch();
  cft_out_if out_ch();

  cumulative_frequency_table #(.MAX_SYMBOLS(MAX_SYM)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_if    (in_ch),
    .out_if   (out_ch)
  );

  // Frequency table copy
  logic [WORD_W-1:0] freq_mem [MAX_SYM];
  logic [WORD_W-1:0] freq_total;
  logic [CFG_W-1:0]  alpha_size;

  freq_result_t pending_results[$];

  int  mismatches;
  int  results_seen;
  int  n_ok;
  int  n_range;
  int  n_overflow;
  int  cycle_count;
  bit  quiet_mode;
  int  stall_orders;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("[%0t] mismatch on %s: got 0x%08h, want 0x%08h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic freq_result_t apply_command(input logic [CMD_W-1:0]  cmd,
                                                 input logic [SYM_W-1:0]  sym,
                                                 input logic [WORD_W-1:0] val);
    freq_result_t res;
    logic [WORD_W:0] next_total;
    logic [63:0]     below;
    int              eff;
    res = '0;
    eff = (alpha_size > MAX_SYM) ? MAX_SYM : int'(alpha_size);
    if (int'(sym) >= eff) begin
      res.status      = STAT_RANGE;
      res.grand_total = freq_total;
      return res;
    end
    res.status = STAT_OK;
    if (cmd == CMD_INC) begin
      if (freq_mem[sym] == WORD_MAX || freq_total == WORD_MAX) begin
        res.status = STAT_OVERFLOW;
      end else begin
        freq_mem[sym] = freq_mem[sym] + 1'b1;
        freq_total    = freq_total + 1'b1;
      end
    end else if (cmd == CMD_SET) begin
      next_total = {1'b0, freq_total} - {1'b0, freq_mem[sym]} + {1'b0, val};
      if (next_total > {1'b0, WORD_MAX}) begin
        res.status = STAT_OVERFLOW;
      end else begin
        freq_mem[sym] = val;
        freq_total    = next_total[WORD_W-1:0];
      end
    end
    below = '0;
    for (int i = 0; i < int'(sym); i++) below += freq_mem[i];
    res.cum_low     = below[WORD_W-1:0];
    res.count       = freq_mem[sym];
    res.cum_high    = res.cum_low + res.count;
    res.grand_total = freq_total;
    return res;
  endfunction

  // Result sink: random hold-offs, plus long stalls on request
  always @(posedge clk) begin : drive_result_ready
    int stall_left;
    int stall_served;
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else if (stall_served != stall_orders) begin
      stall_served = stall_orders;
      stall_left   = STALL_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= quiet_mode || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check_result
    freq_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result item", out_ch.grand_total, '0);
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (out_ch.status !== want.status)
          report_mismatch("status", WORD_W'(out_ch.status), WORD_W'(want.status));
        if (out_ch.cum_low !== want.cum_low)
          report_mismatch("cum_low", out_ch.cum_low, want.cum_low);
        if (out_ch.cum_high !== want.cum_high)
          report_mismatch("cum_high", out_ch.cum_high, want.cum_high);
        if (out_ch.count !== want.count)
          report_mismatch("count", out_ch.count, want.count);
        if (out_ch.grand_total !== want.grand_total)
          report_mismatch("grand_total", out_ch.grand_total, want.grand_total);
      end
    end
  end

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym,
                           input logic [WORD_W-1:0] val);
    freq_result_t res;
    if (!quiet_mode) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.symbol    <= sym;
    in_ch.new_count <= val;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    res = apply_command(cmd, sym, val);
    pending_results.insert(pending_results.size(), res);
    case (res.status)
      STAT_OK:    n_ok++;
      STAT_RANGE: n_range++;
      default:    n_overflow++;
    endcase
  endtask

  // Hold until every result is back and the sequencer is idle
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0 || in_ch.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic write_alphabet(input logic [CFG_W-1:0] size);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= size;
    @(posedge clk);
    cfg_we     <= 1'b0;
    alpha_size = size;
  endtask

  task automatic test_basic_commands();
    write_alphabet(CFG_RESET);
    send_item(CMD_QUERY, 8'd0, 32'hFFFF_FFFF);
    send_item(CMD_QUERY, 8'd255, '0);
    send_item(CMD_SET, 8'd0, 32'd5);
    send_item(CMD_SET, 8'd255, 32'd7);
    send_item(CMD_INC, 8'd255, 32'hA5A5_5A5A);
    send_item(CMD_QUERY, 8'd128, '0);
    send_item(CMD_SPARE, 8'd255, 32'd99);
  endtask

  task automatic test_overflow();
    // total is 13 here
    send_item(CMD_SET, 8'd10, WORD_MAX - 32'd13);
    send_item(CMD_INC, 8'd10, '0);
    send_item(CMD_SET, 8'd11, 32'd1);
    send_item(CMD_SET, 8'd10, WORD_MAX - 32'd14);
    send_item(CMD_INC, 8'd10, '0);
    send_item(CMD_SET, 8'd0, '0);
    send_item(CMD_SET, 8'd255, '0);
    send_item(CMD_SET, 8'd10, WORD_MAX);
    send_item(CMD_INC, 8'd10, '0);
    send_item(CMD_SET, 8'd10, '0);
  endtask

  task automatic test_alphabet_limits();
    write_alphabet(9'd0);
    send_item(CMD_QUERY, 8'd0, '0);
    write_alphabet(9'd1);
    send_item(CMD_QUERY, 8'd0, '0);
    send_item(CMD_INC, 8'd1, '0);
    write_alphabet(9'd511);
    send_item(CMD_QUERY, 8'd255, '0);
  endtask

  task automatic test_random_traffic(input int n_items, input logic [CFG_W-1:0] size,
                                     input bit steady);
    int                eff;
    int                pick;
    logic [CMD_W-1:0]  cmd;
    logic [SYM_W-1:0]  sym;
    logic [WORD_W-1:0] val;
    write_alphabet(size);
    quiet_mode = steady;
    eff = (size > MAX_SYM) ? MAX_SYM : int'(size);
    repeat (n_items) begin
      pick = $urandom_range(99);
      if (pick < 70 && eff > 0) begin
        sym = SYM_W'($urandom_range(eff - 1, 0));
      end else if (pick < 90) begin
        sym = SYM_W'($urandom_range(255, 0));
      end else begin
        case ($urandom_range(3))
          0:       sym = '0;
          1:       sym = SYM_W'(eff - 1);
          2:       sym = SYM_W'(eff);
          default: sym = '1;
        endcase
      end
      val  = $urandom_range(5000, 0);
      pick = $urandom_range(99);
      if (pick < 30) begin
        cmd = CMD_QUERY;
        val = $urandom;
      end else if (pick < 55) begin
        cmd = CMD_INC;
      end else if (pick < 85) begin
        cmd = CMD_SET;
      end else if (pick < 93) begin
        cmd = CMD_SET;
        val = $urandom;
      end else if (pick < 96) begin
        cmd = CMD_SET;
        val = '0;
      end else begin
        cmd = CMD_SPARE;
        val = $urandom;
      end
      send_item(cmd, sym, val);
    end
    quiet_mode = 1'b0;
  endtask

  task automatic test_output_stall();
    write_alphabet(9'd128);
    @(posedge clk);
    stall_orders <= stall_orders + 1;
    repeat (40) send_item(CMD_INC, SYM_W'($urandom_range(127, 0)), '0);
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.command   = '0;
    in_ch.symbol    = '0;
    in_ch.new_count = '0;
    out_ch.ready    = 1'b0;
    quiet_mode      = 1'b0;
    stall_orders    = 0;
    for (int i = 0; i < MAX_SYM; i++) freq_mem[i] = '0;
    freq_total = '0;
    alpha_size = CFG_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_basic_commands();
    test_overflow();
    test_alphabet_limits();
    test_random_traffic(350, 9'd256, 1'b0);
    test_random_traffic(250, 9'd37, 1'b0);
    test_random_traffic(200, 9'd256, 1'b1);
    test_output_stall();
    test_random_traffic(150, 9'd255, 1'b0);
    test_random_traffic(60, 9'd1, 1'b0);
    test_random_traffic(150, 9'd511, 1'b0);
    test_random_traffic(40, 9'd2, 1'b0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", WORD_W'(pending_results.size()), '0);

    $display("checked %0d results: %0d ok, %0d symbol out of range, %0d overflow",
             results_seen, n_ok, n_range, n_overflow);
    $display("alphabet sizes 0 to 511, spare command code, %0d-cycle output stall",
             STALL_CYCLES);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
